>>> hdl/bmp2pnm_pkg.sv
// bmp2pnm_pkg: shared types and constants for the bmp raster to pnm stream core
// token and pixel records passed between front, queue, unpack and emit stages
// no dependencies
package bmp2pnm_pkg;

	localparam int MAX_COLS       = 4096;
	localparam int PBM_LINE_LIMIT = 70;
	localparam int COL_W          = 14;
	localparam int LINE_W         = 7;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = 2;
	localparam int BPP_W          = 6;
	localparam int ROW_W          = 13;
	localparam int FMT_W          = 2;
	localparam int CFG_W          = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int IN_DATA_W      = 40;

	localparam logic [FMT_W-1:0] FMT_PPM = 2'd0;
	localparam logic [FMT_W-1:0] FMT_PGM = 2'd1;
	localparam logic [FMT_W-1:0] FMT_PBM = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BPP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FMT = 2'd2;

	localparam logic [7:0] CHAR_NL   = 8'd10;
	localparam logic [7:0] CHAR_ONE  = 8'h31;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef enum logic [1:0] {
		TOK_PAL,
		TOK_IDX,
		TOK_RGB
	} tok_kind_t;

	// byte_val is the palette index for TOK_PAL, the raster byte for TOK_IDX
	typedef struct packed {
		tok_kind_t   kind;
		logic [23:0] color;
		logic [7:0]  byte_val;
		logic [1:0]  lg;
		logic [3:0]  count;
		logic        row_end;
	} token_t;

	typedef struct packed {
		logic [23:0] rgb;
		logic        row_end;
		logic        item_last;
	} pixel_t;

	// 5-bit field to 8 bits, floor(v * 255 / 31)
	function automatic logic [7:0] scale5(input logic [4:0] v);
		logic [7:0] r;
		case (v)
			5'd0:  r = 8'd0;
			5'd1:  r = 8'd8;
			5'd2:  r = 8'd16;
			5'd3:  r = 8'd24;
			5'd4:  r = 8'd32;
			5'd5:  r = 8'd41;
			5'd6:  r = 8'd49;
			5'd7:  r = 8'd57;
			5'd8:  r = 8'd65;
			5'd9:  r = 8'd74;
			5'd10: r = 8'd82;
			5'd11: r = 8'd90;
			5'd12: r = 8'd98;
			5'd13: r = 8'd106;
			5'd14: r = 8'd115;
			5'd15: r = 8'd123;
			5'd16: r = 8'd131;
			5'd17: r = 8'd139;
			5'd18: r = 8'd148;
			5'd19: r = 8'd156;
			5'd20: r = 8'd164;
			5'd21: r = 8'd172;
			5'd22: r = 8'd180;
			5'd23: r = 8'd189;
			5'd24: r = 8'd197;
			5'd25: r = 8'd205;
			5'd26: r = 8'd213;
			5'd27: r = 8'd222;
			5'd28: r = 8'd230;
			5'd29: r = 8'd238;
			5'd30: r = 8'd246;
			default: r = 8'd255;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/bmp2pnm_front.sv
// bmp2pnm_front: accepts input items, gathers multi-byte pixels, tracks row position
// emits one token per item that has work for the back end
// depends on bmp2pnm_pkg
module bmp2pnm_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   restart,
	input  logic [bmp2pnm_pkg::BPP_W-1:0]          bpp,
	input  logic [bmp2pnm_pkg::COL_W-1:0]          row_len,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [bmp2pnm_pkg::IN_DATA_W-1:0]      s_tdata,  // raster_byte, palette_index, palette_color
	input  logic                                   s_tuser,  // kind
	input  logic                                   q_full,
	output logic                                   q_push,
	output bmp2pnm_pkg::token_t                    q_tok
);

	logic [23:0]                      gather_q, gather_d;
	logic [1:0]                       slot_q, slot_d;
	logic [bmp2pnm_pkg::COL_W-1:0]    col_q, col_d;

	logic                             accept;
	logic [7:0]                       raster;
	logic [1:0]                       lg;
	logic [3:0]                       per, n;
	logic [bmp2pnm_pkg::COL_W-1:0]    left, col_n, col_one;
	logic                             end_n, end_one;
	logic [15:0]                      word;
	logic [23:0]                      merged;
	logic [1:0]                       last_slot;

	assign accept   = s_tvalid && !q_full;
	assign s_tready = !q_full;
	assign raster   = s_tdata[7:0];
	assign word     = {raster, gather_q[7:0]};

	always_comb begin
		case (bpp)
			6'd1:    lg = 2'd0;
			6'd2:    lg = 2'd1;
			6'd4:    lg = 2'd2;
			default: lg = 2'd3;
		endcase
		per     = 4'd8 >> lg;
		left    = row_len - col_q;
		n       = (left < {{(bmp2pnm_pkg::COL_W-4){1'b0}}, per}) ? left[3:0] : per;
		col_n   = col_q + {{(bmp2pnm_pkg::COL_W-4){1'b0}}, n};
		col_one = col_q + {{(bmp2pnm_pkg::COL_W-1){1'b0}}, 1'b1};
		end_n   = col_n >= row_len;
		end_one = col_one >= row_len;
		last_slot = (bpp == 6'd24) ? 2'd2 : 2'd3;
		merged  = (slot_q != 2'd3) ? (gather_q | (24'(raster) << {slot_q, 3'b000})) : gather_q;
	end

	always_comb begin
		gather_d = gather_q;
		slot_d   = slot_q;
		col_d    = col_q;
		q_push   = 1'b0;
		q_tok    = '0;
		q_tok.lg = lg;
		if (accept) begin
			if (s_tuser) begin
				q_push         = 1'b1;
				q_tok.kind     = bmp2pnm_pkg::TOK_PAL;
				q_tok.byte_val = s_tdata[15:8];
				q_tok.color    = s_tdata[39:16];
			end else begin
				case (bpp)
					6'd1, 6'd2, 6'd4, 6'd8: begin
						q_push         = 1'b1;
						q_tok.kind     = bmp2pnm_pkg::TOK_IDX;
						q_tok.byte_val = raster;
						q_tok.count    = n;
						q_tok.row_end  = end_n;
						col_d          = end_n ? '0 : col_n;
					end
					6'd16: begin
						if (slot_q == 2'd0) begin
							gather_d = {16'd0, raster};
							slot_d   = 2'd1;
						end else begin
							q_push        = 1'b1;
							q_tok.kind    = bmp2pnm_pkg::TOK_RGB;
							q_tok.color   = {bmp2pnm_pkg::scale5(word[14:10]),
								bmp2pnm_pkg::scale5(word[9:5]), bmp2pnm_pkg::scale5(word[4:0])};
							q_tok.row_end = end_one;
							gather_d      = '0;
							slot_d        = 2'd0;
							col_d         = end_one ? '0 : col_one;
						end
					end
					6'd24, 6'd32: begin
						if (slot_q >= last_slot) begin
							q_push        = 1'b1;
							q_tok.kind    = bmp2pnm_pkg::TOK_RGB;
							q_tok.color   = merged;
							q_tok.row_end = end_one;
							gather_d      = '0;
							slot_d        = 2'd0;
							col_d         = end_one ? '0 : col_one;
						end else begin
							gather_d = merged;
							slot_d   = slot_q + 2'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			slot_q   <= '0;
			col_q    <= '0;
		end else if (restart) begin
			gather_q <= '0;
			slot_q   <= '0;
			col_q    <= '0;
		end else begin
			gather_q <= gather_d;
			slot_q   <= slot_d;
			col_q    <= col_d;
		end
	end

endmodule

>>> hdl/bmp2pnm_queue.sv
// bmp2pnm_queue: short token queue between the front and the back end
// depends on bmp2pnm_pkg
module bmp2pnm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bmp2pnm_pkg::token_t push_tok,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output bmp2pnm_pkg::token_t head_tok
);

	bmp2pnm_pkg::token_t                 slots_q [bmp2pnm_pkg::QUEUE_DEPTH];
	logic [bmp2pnm_pkg::QPTR_W-1:0]      wr_q, rd_q;
	logic [bmp2pnm_pkg::QPTR_W:0]        count_q;

	assign full       = count_q == (bmp2pnm_pkg::QPTR_W + 1)'(bmp2pnm_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_tok   = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/bmp2pnm_unpack.sv
// bmp2pnm_unpack: palette memory and pixel sequencer, one pixel per cycle while px_ready is high
// splits index bytes into pixels, looks up colors, feeds the emitter
// depends on bmp2pnm_pkg
module bmp2pnm_unpack #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  bmp2pnm_pkg::token_t q_tok,
	output logic                q_pop,
	output logic                px_valid,
	input  logic                px_ready,
	output bmp2pnm_pkg::pixel_t px
);

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	logic [23:0] pal_mem [PALETTE_DEPTH];
	logic [23:0] rd_q;
	logic [23:0] rgb_s1;
	logic        row_end_s1, last_s1, from_pal_s1, oob_s1;
	logic        valid_s1;
	logic [2:0]  k_q;

	logic        advance, k_last, load_idx, load_rgb, pal_wr, idx_ok;
	logic [2:0]  shamt;
	logic [7:0]  sh_byte, idx;

	always_comb begin
		case (q_tok.lg)
			2'd0:    shamt = k_q;
			2'd1:    shamt = {k_q[1:0], 1'b0};
			2'd2:    shamt = {k_q[0], 2'b00};
			default: shamt = 3'd0;
		endcase
		sh_byte = q_tok.byte_val << shamt;
		case (q_tok.lg)
			2'd0:    idx = {7'd0, sh_byte[7]};
			2'd1:    idx = {6'd0, sh_byte[7:6]};
			2'd2:    idx = {4'd0, sh_byte[7:4]};
			default: idx = sh_byte;
		endcase
	end

	assign advance  = !valid_s1 || px_ready;
	assign k_last   = ({1'b0, k_q} + 4'd1) == q_tok.count;
	assign idx_ok   = {1'b0, idx} < 9'(PALETTE_DEPTH);
	assign pal_wr   = q_valid && (q_tok.kind == bmp2pnm_pkg::TOK_PAL)
		&& ({1'b0, q_tok.byte_val} < 9'(PALETTE_DEPTH));
	assign load_idx = q_valid && advance && (q_tok.kind == bmp2pnm_pkg::TOK_IDX);
	assign load_rgb = q_valid && advance && (q_tok.kind == bmp2pnm_pkg::TOK_RGB);
	assign q_pop    = (q_valid && (q_tok.kind == bmp2pnm_pkg::TOK_PAL)) || load_rgb
		|| (load_idx && k_last);

	assign px_valid     = valid_s1;
	assign px.rgb       = from_pal_s1 ? (oob_s1 ? 24'd0 : rd_q) : rgb_s1;
	assign px.row_end   = row_end_s1;
	assign px.item_last = last_s1;

	always_ff @(posedge clk) begin
		if (pal_wr) begin
			pal_mem[q_tok.byte_val[PAL_AW-1:0]] <= q_tok.color;
		end
		if (load_idx) begin
			rd_q <= pal_mem[idx[PAL_AW-1:0]];
		end
		if (load_idx || load_rgb) begin
			rgb_s1      <= q_tok.color;
			from_pal_s1 <= load_idx;
			oob_s1      <= !idx_ok;
			last_s1     <= load_rgb || k_last;
			row_end_s1  <= q_tok.row_end && (load_rgb || k_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			k_q      <= '0;
		end else begin
			if (advance) begin
				valid_s1 <= load_idx || load_rgb;
			end
			if (load_idx) begin
				k_q <= k_last ? 3'd0 : k_q + 3'd1;
			end
		end
	end

	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("token popped from empty queue");

endmodule

>>> hdl/bmp2pnm_emit.sv
// bmp2pnm_emit: expands pixels into ppm, pgm or plain pbm bytes, one byte per cycle while m_tready is high
// owns the pbm line counter and the output register
// depends on bmp2pnm_pkg
module bmp2pnm_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic [bmp2pnm_pkg::FMT_W-1:0]     fmt,
	input  logic                              px_valid,
	input  bmp2pnm_pkg::pixel_t               px,
	output logic                              px_ready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // out_byte
	output logic                              m_tlast   // run_last
);

	localparam logic [bmp2pnm_pkg::LINE_W-1:0] LIMIT = bmp2pnm_pkg::LINE_W'(bmp2pnm_pkg::PBM_LINE_LIMIT);

	logic [1:0]                       step_q, step_d;
	logic [bmp2pnm_pkg::LINE_W-1:0]   line_q, line_d;
	logic                             m_tvalid_q, m_tlast_q;
	logic [7:0]                       m_tdata_q;

	logic                             can_emit, fire, final_d, wrap;
	logic [7:0]                       byte_d, blue;

	assign can_emit = !m_tvalid_q || m_tready;
	assign fire     = px_valid && can_emit;
	assign blue     = px.rgb[7:0];
	assign wrap     = (step_q == 2'd0) && (line_q >= LIMIT);

	always_comb begin
		byte_d  = blue;
		final_d = 1'b0;
		step_d  = step_q;
		line_d  = line_q;
		case (fmt)
			bmp2pnm_pkg::FMT_PPM: begin
				case (step_q)
					2'd0: begin
						byte_d = px.rgb[23:16];
						step_d = 2'd1;
					end
					2'd1: begin
						byte_d = px.rgb[15:8];
						step_d = 2'd2;
					end
					default: begin
						byte_d  = blue;
						final_d = 1'b1;
					end
				endcase
			end
			bmp2pnm_pkg::FMT_PGM: begin
				byte_d  = blue;
				final_d = 1'b1;
			end
			default: begin
				if (wrap) begin
					byte_d = bmp2pnm_pkg::CHAR_NL;
					line_d = '0;
				end else if (step_q == 2'd0) begin
					byte_d  = (blue == 8'd0) ? bmp2pnm_pkg::CHAR_ONE : bmp2pnm_pkg::CHAR_ZERO;
					line_d  = line_q + 1'b1;
					final_d = !px.row_end;
					step_d  = 2'd1;
				end else begin
					byte_d  = bmp2pnm_pkg::CHAR_NL;
					line_d  = '0;
					final_d = 1'b1;
				end
			end
		endcase
		if (final_d) begin
			step_d = 2'd0;
			if (px.row_end) begin
				line_d = '0;
			end
		end
	end

	assign px_ready = fire && final_d;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			line_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (restart) begin
				step_q <= '0;
				line_q <= '0;
			end else if (fire) begin
				step_q <= step_d;
				line_q <= line_d;
			end
			if (can_emit) begin
				m_tvalid_q <= fire;
			end
			if (fire) begin
				m_tdata_q <= byte_d;
				m_tlast_q <= final_d && px.item_last;
			end
		end
	end

	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n) line_q <= LIMIT)
		else $error("pbm line count past limit");

	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && fmt[1] && wrap) |=> (line_q == '0))
		else $error("pbm wrap newline did not clear line count");

endmodule

>>> hdl/bmp_raster_to_pnm_stream_core.sv
// bmp_raster_to_pnm_stream_core: data passes the token queue, unpack stage and output register
// throughput: one output byte per cycle from the emitter while m_tready is high; an input
// item per cycle while the four-entry token queue has room; ppm sends three bytes per pixel,
// so the output port paces it; unpack splits sub-byte depths pixel by pixel (one palette read port)
// reset: arst_n clears all control state; palette contents are undefined until written
// depends on bmp2pnm_pkg, bmp2pnm_front, bmp2pnm_queue, bmp2pnm_unpack, bmp2pnm_emit
module bmp_raster_to_pnm_stream_core #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bmp2pnm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmp2pnm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [bmp2pnm_pkg::IN_DATA_W-1:0]     s_tdata,  // raster_byte, palette_index, palette_color
	input  logic                                  s_tuser,  // kind
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,  // out_byte
	output logic                                  m_tlast   // run_last
);

	localparam int LEN_CAP = (bmp2pnm_pkg::MAX_COLS < 8191) ? bmp2pnm_pkg::MAX_COLS : 8191;

	logic [bmp2pnm_pkg::BPP_W-1:0]   bpp_q;
	logic [bmp2pnm_pkg::ROW_W-1:0]   row_pixels_q;
	logic [bmp2pnm_pkg::FMT_W-1:0]   fmt_q;
	logic                            restart;
	logic [bmp2pnm_pkg::COL_W-1:0]   row_len;

	logic                            q_push, q_full, q_pop, q_valid, px_valid, px_ready;
	bmp2pnm_pkg::token_t             push_tok, head_tok;
	bmp2pnm_pkg::pixel_t             px;

	assign restart = cfg_wr_en && ((cfg_index == bmp2pnm_pkg::REG_BPP)
		|| (cfg_index == bmp2pnm_pkg::REG_ROW) || (cfg_index == bmp2pnm_pkg::REG_FMT));

	always_comb begin
		if (row_pixels_q == '0) begin
			row_len = bmp2pnm_pkg::COL_W'(1);
		end else if ({1'b0, row_pixels_q} > bmp2pnm_pkg::COL_W'(LEN_CAP)) begin
			row_len = bmp2pnm_pkg::COL_W'(LEN_CAP);
		end else begin
			row_len = {1'b0, row_pixels_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q        <= 6'd24;
			row_pixels_q <= 13'd1;
			fmt_q        <= bmp2pnm_pkg::FMT_PPM;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bmp2pnm_pkg::REG_BPP: bpp_q        <= cfg_data[bmp2pnm_pkg::BPP_W-1:0];
				bmp2pnm_pkg::REG_ROW: row_pixels_q <= cfg_data[bmp2pnm_pkg::ROW_W-1:0];
				bmp2pnm_pkg::REG_FMT: fmt_q        <= cfg_data[bmp2pnm_pkg::FMT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bmp2pnm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.bpp      (bpp_q),
		.row_len  (row_len),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_tok    (push_tok)
	);

	bmp2pnm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_tok   (push_tok),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_tok   (head_tok)
	);

	bmp2pnm_unpack #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_tok    (head_tok),
		.q_pop    (q_pop),
		.px_valid (px_valid),
		.px_ready (px_ready),
		.px       (px)
	);

	bmp2pnm_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.fmt      (fmt_q),
		.px_valid (px_valid),
		.px       (px),
		.px_ready (px_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("token pushed into full queue");

endmodule
